// ===== rtl/rrpu_pkg.sv =====
// ----------------------------------------------------------------------------
// rrpu_pkg
// Shared types, widths and helpers of the rigid pose update core.
// ----------------------------------------------------------------------------
package rrpu_pkg;

  localparam int WORD_BITS = 32;
  localparam int DEN_W     = 38;   // 2^32 + (|a|^2 >> 28)
  localparam int NUM_W     = 63;   // 2^62 + den/2
  localparam int GAIN_W    = 31;   // gain in Q1.30, at most 2^30
  localparam int OPA_W     = 36;
  localparam int OPB_W     = 33;
  localparam int PROD_W    = OPA_W + OPB_W;
  localparam int WIDE_W    = 70;

  localparam logic [1:0] ACT_LOAD   = 2'd0;
  localparam logic [1:0] ACT_UPDATE = 2'd1;
  localparam logic [1:0] ACT_COMMIT = 2'd2;
  localparam logic [1:0] ACT_NOP    = 2'd3;

  localparam logic signed [WORD_BITS-1:0] ONE_Q30 = 32'sh4000_0000;

  typedef struct packed {
    logic             start;
    logic [DEN_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic              busy;
    logic              done;
    logic [GAIN_W-1:0] quo;
  } div_rsp_t;

  function automatic logic signed [WORD_BITS-1:0] sat_word(input logic signed [WIDE_W-1:0] v);
    logic signed [WIDE_W-1:0] hi;
    logic signed [WIDE_W-1:0] lo;
    hi = WIDE_W'(64'sh7FFF_FFFF);
    lo = -hi - WIDE_W'(1);
    if (v > hi) return ONE_Q30 + 32'sh3FFF_FFFF;
    else if (v < lo) return -ONE_Q30 - ONE_Q30;
    else return v[WORD_BITS-1:0];
  endfunction

endpackage

// ===== rtl/rrpu_mul.sv =====
// ----------------------------------------------------------------------------
// rrpu_mul
// Shared signed multiplier with registered product.
// ----------------------------------------------------------------------------
module rrpu_mul
  import rrpu_pkg::*;
(
  input  logic                     clk_i,
  input  logic signed [OPA_W-1:0]  a_i,
  input  logic signed [OPB_W-1:0]  b_i,
  output logic signed [PROD_W-1:0] p_o
);

  logic signed [PROD_W-1:0] p_q;

  always_ff @(posedge clk_i) begin
    p_q <= PROD_W'(a_i) * PROD_W'(b_i);
  end

  assign p_o = p_q;

endmodule

// ===== rtl/rrpu_div.sv =====
// ----------------------------------------------------------------------------
// rrpu_div
// Restoring divider, one quotient bit per cycle: (2^62 + den/2) / den.
// ----------------------------------------------------------------------------
module rrpu_div
  import rrpu_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  logic [DEN_W-1:0]  rem_q;
  logic [DEN_W-1:0]  den_q;
  logic [NUM_W-1:0]  num_q;
  logic [GAIN_W-1:0] quo_q;
  logic [5:0]        cnt_q;
  logic              busy_q;
  logic              done_q;
  logic [DEN_W:0]    trial;
  logic              fits;

  assign trial = {rem_q, num_q[NUM_W-1]};
  assign fits  = trial >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 6'd1;
        if (cnt_q == 6'(NUM_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q <= '0;
      den_q <= req_i.den;
      num_q <= {1'b1, {(NUM_W-1){1'b0}}} + NUM_W'(req_i.den >> 1);
      quo_q <= '0;
    end else if (busy_q) begin
      rem_q <= fits ? DEN_W'(trial - {1'b0, den_q}) : trial[DEN_W-1:0];
      num_q <= num_q << 1;
      quo_q <= {quo_q[GAIN_W-2:0], fits};
    end
  end

  assign rsp_o.busy = busy_q;
  assign rsp_o.done = done_q;
  assign rsp_o.quo  = quo_q;

endmodule

// ===== rtl/rodrigues_rigid_pose_update_core.sv =====
// ----------------------------------------------------------------------------
// rodrigues_rigid_pose_update_core
// Rigid pose update: reference pose, rotation-vector increment and commit.
// ----------------------------------------------------------------------------
// Usage:
//   Input transactions arrive on s_axis_*: tuser carries the action (load,
//   update, commit), tdata the displacement, rotation vector and load data.
//   Every transaction returns one transaction on m_axis_* with the current
//   pose after that action.
//   Load, commit and unknown actions pass through ST_FIN to the output register.
//   Update passes each product through the single shared multiplier, with
//   an issue step and then an accumulate step - 6 squares and cross
//   products, 9 gain products, 27 matrix products - and waits between the
//   squares and the gain products for the bit-serial divider that forms the gain.
//   The block takes one item at a time; s_axis_tready is high only while
//   the sequencer is idle. A finished result waits in the output register,
//   and the next item may be accepted meanwhile; a further result then
//   waits until the receiver takes the earlier one.
//   Reset sets both poses to identity rotation and zero position.
// ----------------------------------------------------------------------------
module rodrigues_rigid_pose_update_core
  import rrpu_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // disp_x, disp_y, disp_z, rotvec_x, rotvec_y, rotvec_z, load_index[3:0],
  // load_value, 4 zero bits
  input  logic [231:0] s_axis_tdata,
  // action
  input  logic [1:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // pos_x, pos_y, pos_z, rot_00 .. rot_22 row-major
  output logic [383:0] m_axis_tdata
);

  typedef enum logic [2:0] {
    ST_IDLE, ST_SQ, ST_DIV, ST_GAIN, ST_ROT, ST_FIN
  } state_e;

  typedef logic signed [WORD_BITS-1:0] word_t;

  state_e state_q;
  logic   ph_q;
  logic [3:0] cnt_q;
  logic [1:0] ri_q, rj_q, rk_q;
  logic   div_start_q;

  word_t ref_rot_q [9];
  word_t cur_rot_q [9];
  word_t ref_pos_q [3];
  word_t cur_pos_q [3];
  word_t a_q       [3];
  word_t q_q       [9];
  logic [63:0] sq0_q, sq1_q, sq2_q;
  logic signed [63:0] p01_q, p02_q, p12_q;
  logic [GAIN_W-1:0] g_q;
  logic signed [65:0] acc_q;
  logic [383:0] out_q;
  logic out_vld_q;

  logic signed [OPA_W-1:0]  op_a;
  logic signed [OPB_W-1:0]  op_b;
  logic signed [PROD_W-1:0] prod;
  div_req_t div_req;
  div_rsp_t div_rsp;

  logic in_acc;
  logic [1:0] act;
  logic [3:0] ld_idx;
  word_t ld_val;
  word_t disp [3];
  word_t rv   [3];

  assign in_acc = s_axis_tvalid && s_axis_tready;
  assign act    = s_axis_tuser;
  assign ld_idx = s_axis_tdata[195:192];
  assign ld_val = s_axis_tdata[227:196];
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      disp[i] = s_axis_tdata[32*i +: 32];
      rv[i]   = s_axis_tdata[96 + 32*i +: 32];
    end
  end

  // norm and divisor
  logic [65:0] s_sum;
  assign s_sum = {2'b0, sq0_q} + {2'b0, sq1_q} + {2'b0, sq2_q};
  assign div_req.start = div_start_q;
  assign div_req.den   = DEN_W'(38'h1_0000_0000) + s_sum[65:28];

  // element of A + A*A in Q.59, selected by cnt_q
  function automatic logic signed [65:0] diag_m(input logic [63:0] x, input logic [63:0] y);
    logic [65:0] s;
    s = ({2'b0, x} + {2'b0, y}) >> 1;
    return -$signed(s);
  endfunction

  function automatic logic signed [65:0] off_m(input word_t a, input logic neg,
                                               input logic signed [63:0] p);
    logic signed [65:0] t;
    t = $signed({{5{a[WORD_BITS-1]}}, a, 29'b0});
    return (neg ? -t : t) + ($signed({{2{p[63]}}, p}) >>> 1);
  endfunction

  logic signed [65:0] m_s, m_r;
  logic [65:0] m_mag;
  logic is_diag;

  always_comb begin
    unique case (cnt_q)
      4'd0:    m_s = diag_m(sq1_q, sq2_q);
      4'd1:    m_s = off_m(a_q[2], 1'b1, p01_q);
      4'd2:    m_s = off_m(a_q[1], 1'b0, p02_q);
      4'd3:    m_s = off_m(a_q[2], 1'b0, p01_q);
      4'd4:    m_s = diag_m(sq0_q, sq2_q);
      4'd5:    m_s = off_m(a_q[0], 1'b1, p12_q);
      4'd6:    m_s = off_m(a_q[1], 1'b1, p02_q);
      4'd7:    m_s = off_m(a_q[0], 1'b0, p12_q);
      default: m_s = diag_m(sq0_q, sq1_q);
    endcase
    m_r     = (m_s + 66'sd134217728) >>> 28;
    m_mag   = m_r[65] ? 66'(-m_r) : 66'(m_r);
    is_diag = (cnt_q == 4'd0) || (cnt_q == 4'd4) || (cnt_q == 4'd8);
  end

  logic [3:0] qi, ei, rki;
  assign qi  = 4'(ri_q) * 4'd3 + 4'(rk_q);
  assign rki = 4'(rk_q) * 4'd3 + 4'(rj_q);
  assign ei  = 4'(ri_q) * 4'd3 + 4'(rj_q);

  // operand select for the shared multiplier
  always_comb begin
    op_a = '0;
    op_b = '0;
    unique case (state_q)
      ST_SQ: begin
        case (cnt_q)
          4'd0: begin op_a = OPA_W'(a_q[0]); op_b = OPB_W'(a_q[0]); end
          4'd1: begin op_a = OPA_W'(a_q[1]); op_b = OPB_W'(a_q[1]); end
          4'd2: begin op_a = OPA_W'(a_q[2]); op_b = OPB_W'(a_q[2]); end
          4'd3: begin op_a = OPA_W'(a_q[0]); op_b = OPB_W'(a_q[1]); end
          4'd4: begin op_a = OPA_W'(a_q[0]); op_b = OPB_W'(a_q[2]); end
          default: begin op_a = OPA_W'(a_q[1]); op_b = OPB_W'(a_q[2]); end
        endcase
      end
      ST_GAIN: begin
        op_a = $signed({1'b0, m_mag[34:0]});
        op_b = $signed({2'b0, g_q});
      end
      ST_ROT: begin
        op_a = OPA_W'(q_q[qi]);
        op_b = OPB_W'(ref_rot_q[rki]);
      end
      default: ;
    endcase
  end

  rrpu_mul u_mul (
    .clk_i (clk_i),
    .a_i   (op_a),
    .b_i   (op_b),
    .p_o   (prod)
  );

  rrpu_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // gain product: round half away on magnitude, restore sign, add one on the diagonal
  logic signed [WIDE_W-1:0] g_rnd, g_val;
  assign g_rnd = (WIDE_W'(prod) + WIDE_W'(70'sd536870912)) >>> 30;
  assign g_val = (m_r[65] ? -g_rnd : g_rnd) + (is_diag ? WIDE_W'(ONE_Q30) : '0);

  // rotation accumulate
  logic signed [65:0] acc_new, rot_r;
  assign acc_new = ((rk_q == 2'd0) ? 66'sd0 : acc_q) + 66'(prod >>> 2);
  assign rot_r   = (acc_new + 66'sd134217728) >>> 28;

  logic [383:0] pose_bus;
  always_comb begin
    for (int i = 0; i < 3; i++) pose_bus[32*i +: 32] = cur_pos_q[i];
    for (int i = 0; i < 9; i++) pose_bus[96 + 32*i +: 32] = cur_rot_q[i];
  end

  logic out_free;
  assign out_free = !out_vld_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      ph_q        <= 1'b0;
      cnt_q       <= '0;
      ri_q        <= '0;
      rj_q        <= '0;
      rk_q        <= '0;
      div_start_q <= 1'b0;
      out_vld_q   <= 1'b0;
      for (int i = 0; i < 9; i++) begin
        ref_rot_q[i] <= (i % 4 == 0) ? ONE_Q30 : '0;
        cur_rot_q[i] <= (i % 4 == 0) ? ONE_Q30 : '0;
      end
      for (int i = 0; i < 3; i++) begin
        ref_pos_q[i] <= '0;
        cur_pos_q[i] <= '0;
      end
    end else begin
      div_start_q <= 1'b0;
      if (state_q == ST_FIN && out_free) out_vld_q <= 1'b1;
      else if (m_axis_tready) out_vld_q <= 1'b0;
      unique case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            state_q <= (act == ACT_UPDATE) ? ST_SQ : ST_FIN;
            case (act)
              ACT_LOAD: begin
                if (ld_idx < 4'd9) ref_rot_q[ld_idx] <= ld_val;
                else if (ld_idx < 4'd12) ref_pos_q[2'(ld_idx - 4'd9)] <= ld_val;
              end
              ACT_UPDATE: begin
                for (int i = 0; i < 3; i++)
                  cur_pos_q[i] <= sat_word(WIDE_W'(ref_pos_q[i]) + WIDE_W'(disp[i]));
                cnt_q   <= '0;
                ph_q    <= 1'b0;
              end
              ACT_COMMIT: begin
                ref_rot_q <= cur_rot_q;
                ref_pos_q <= cur_pos_q;
              end
              default: ;
            endcase
          end
        end
        ST_SQ: begin
          ph_q <= !ph_q;
          if (ph_q) begin
            cnt_q <= cnt_q + 4'd1;
            if (cnt_q == 4'd5) begin
              div_start_q <= 1'b1;
              state_q     <= ST_DIV;
            end
          end
        end
        ST_DIV: begin
          if (div_rsp.done) begin
            cnt_q   <= '0;
            ph_q    <= 1'b0;
            state_q <= ST_GAIN;
          end
        end
        ST_GAIN: begin
          ph_q <= !ph_q;
          if (ph_q) begin
            cnt_q <= cnt_q + 4'd1;
            if (cnt_q == 4'd8) begin
              ri_q    <= '0;
              rj_q    <= '0;
              rk_q    <= '0;
              state_q <= ST_ROT;
            end
          end
        end
        ST_ROT: begin
          ph_q <= !ph_q;
          if (ph_q) begin
            if (rk_q == 2'd2) begin
              cur_rot_q[ei] <= sat_word(WIDE_W'(rot_r));
              rk_q <= '0;
              if (rj_q == 2'd2) begin
                rj_q <= '0;
                if (ri_q == 2'd2) state_q <= ST_FIN;
                else ri_q <= ri_q + 2'd1;
              end else begin
                rj_q <= rj_q + 2'd1;
              end
            end else begin
              rk_q <= rk_q + 2'd1;
            end
          end
        end
        ST_FIN: begin
          if (out_free) begin
            state_q   <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // datapath registers without reset
  always_ff @(posedge clk_i) begin
    if (in_acc && act == ACT_UPDATE) a_q <= rv;
    if (state_q == ST_SQ && ph_q) begin
      case (cnt_q)
        4'd0:    sq0_q <= prod[63:0];
        4'd1:    sq1_q <= prod[63:0];
        4'd2:    sq2_q <= prod[63:0];
        4'd3:    p01_q <= prod[63:0];
        4'd4:    p02_q <= prod[63:0];
        default: p12_q <= prod[63:0];
      endcase
    end
    if (state_q == ST_DIV && div_rsp.done) g_q <= div_rsp.quo;
    if (state_q == ST_GAIN && ph_q) q_q[cnt_q] <= sat_word(g_val);
    if (state_q == ST_ROT && ph_q) acc_q <= acc_new;
    if (state_q == ST_FIN && out_free) out_q <= pose_bus;
  end

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_q;

  a_div_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.done |-> state_q == ST_DIV)
    else $error("divider finished outside its state");

  a_accept_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> state_q != ST_IDLE)
    else $error("accepted transaction did not start work");

  a_fin_shows_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FIN && out_free) |=> m_axis_tvalid)
    else $error("finished transaction not presented");

endmodule
